/* rtl/bsc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the banded symmetric count matrix.
// No dependencies; imported by every module of the block but bsc_fifo.
package bsc_pkg;

  localparam int COORD_W    = 11;
  localparam int VALUE_W    = 32;
  localparam int BAND_W     = 5;
  localparam int BINS_W     = 11;
  localparam int CFG_DATA_W = 11;

  localparam int MAX_DIAGONALS_DEF = 16;
  localparam int MAX_BINS_DEF      = 1024;
  localparam int BAND_WIDTH_RESET  = 16;
  localparam int BIN_COUNT_RESET   = 1024;

  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_GET,
    MODE_INC,
    MODE_SET,
    MODE_DEC
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_OUTSIDE,
    STAT_CLAMPED,
    STAT_SATURATED
  } status_t;

  typedef enum logic {
    REG_BAND_WIDTH,
    REG_BIN_COUNT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } seq_state_t;

  typedef struct packed {
    mode_t                mode;
    logic                 in_band;
    logic [COORD_W-1:0]   diag;
    logic [COORD_W-1:0]   column;
    logic [VALUE_W-1:0]   amount;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] cell_value;
    status_t            status;
  } result_t;

endpackage

/* rtl/banded_symmetric_count_matrix_top.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in_       input      in_push / in_full     in_mode, in_row_bin, in_col_bin, in_amount
// out_      output     out_pop / out_empty   out_cell_value, out_status
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// Each item passes through three sequencer states in the back end (queue pop, store read,
// update and write-back); the next item is popped only once the last is written back.
// A result passes the command queue, these states and the result queue to the out_ ports.
// After reset the store is swept to zero, one word a cycle, over all its
// MAX_DIAGONALS * (MAX_BINS + MAX_DIAGONALS) words (16640 by default); in_full
// stays high for the whole pass. Configuration transfers are taken in every cycle.
// Depends on bsc_pkg, bsc_front and bsc_back.
module banded_symmetric_count_matrix_top
  import bsc_pkg::*;
#(
  parameter int MAX_DIAGONALS = MAX_DIAGONALS_DEF,
  parameter int MAX_BINS      = MAX_BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic [1:0]            in_mode,
  input  logic [COORD_W-1:0]    in_row_bin,
  input  logic [COORD_W-1:0]    in_col_bin,
  input  logic [VALUE_W-1:0]    in_amount,
  output logic                  in_full,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [VALUE_W-1:0]    out_cell_value,
  output logic [1:0]            out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;
  logic clearing;

  bsc_front #(
    .MAX_DIAGONALS (MAX_DIAGONALS),
    .MAX_BINS      (MAX_BINS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_mode    (in_mode),
    .in_row_bin (in_row_bin),
    .in_col_bin (in_col_bin),
    .in_amount  (in_amount),
    .in_full    (in_full),
    .hold       (clearing),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .cmd_empty  (cmd_empty)
  );

  bsc_back #(
    .MAX_DIAGONALS (MAX_DIAGONALS),
    .MAX_BINS      (MAX_BINS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .clearing       (clearing),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_cell_value (out_cell_value),
    .out_status     (out_status)
  );

  // Reset always starts a fresh clearing pass of the store.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> clearing)
    else $error("clearing pass not started after reset");

  // No item may enter while the store is being cleared.
  a_no_entry_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> in_full)
    else $error("input open during clearing pass");

  // Nothing can reach the result queue before the clearing pass ends.
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (out_empty && cmd_empty))
    else $error("work pending during clearing pass");

endmodule

/* rtl/bsc_fifo.sv */
`timescale 1ns / 1ps
// Small synchronous first-in first-out queue built from registers.
// Standalone; used for the command queue and the result queue.
module bsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (PW + 1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/bsc_front.sv */
`timescale 1ns / 1ps
// Front end: configuration registers, cell classification and the command queue.
// Depends on bsc_pkg and bsc_fifo.
module bsc_front
  import bsc_pkg::*;
#(
  parameter int MAX_DIAGONALS = MAX_DIAGONALS_DEF,
  parameter int MAX_BINS      = MAX_BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic [1:0]            in_mode,
  input  logic [COORD_W-1:0]    in_row_bin,
  input  logic [COORD_W-1:0]    in_col_bin,
  input  logic [VALUE_W-1:0]    in_amount,
  output logic                  in_full,
  input  logic                  hold,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  cmd_pop,
  output cmd_t                  cmd,
  output logic                  cmd_empty
);

  localparam int ROW_STRIDE = MAX_BINS + MAX_DIAGONALS;
  localparam logic [BAND_W-1:0] BAND_RST =
    BAND_W'((BAND_WIDTH_RESET > MAX_DIAGONALS) ? MAX_DIAGONALS : BAND_WIDTH_RESET);
  localparam logic [BINS_W-1:0] BINS_RST =
    BINS_W'((BIN_COUNT_RESET > MAX_BINS) ? MAX_BINS : BIN_COUNT_RESET);

  logic [BAND_W-1:0]  band_width_r, band_width_nxt;
  logic [BINS_W-1:0]  bin_count_r, bin_count_nxt;
  logic [BAND_W-1:0]  band_raw;
  logic [BINS_W-1:0]  bins_raw;
  logic [COORD_W-1:0] diag, column;
  logic [BINS_W:0]    column_limit;
  logic               in_band;
  logic               cmd_full;
  logic               accept;
  cmd_t               cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_raw;

  assign cfg_ready = 1'b1;
  assign band_raw  = cfg_wdata[BAND_W-1:0];
  assign bins_raw  = cfg_wdata[BINS_W-1:0];

  // Written values are saturated into the legal range of each register; the band width takes only the low BAND_W bits.
  always_comb begin
    band_width_nxt = band_width_r;
    bin_count_nxt  = bin_count_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_BAND_WIDTH: begin
          if (band_raw == '0) begin
            band_width_nxt = BAND_W'(1);
          end else if (32'(band_raw) > MAX_DIAGONALS) begin
            band_width_nxt = BAND_W'(MAX_DIAGONALS);
          end else begin
            band_width_nxt = band_raw;
          end
        end
        REG_BIN_COUNT: begin
          if (bins_raw == '0) begin
            bin_count_nxt = BINS_W'(1);
          end else if (32'(bins_raw) > MAX_BINS) begin
            bin_count_nxt = BINS_W'(MAX_BINS);
          end else begin
            bin_count_nxt = bins_raw;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_width_r <= BAND_RST;
      bin_count_r  <= BINS_RST;
    end else begin
      band_width_r <= band_width_nxt;
      bin_count_r  <= bin_count_nxt;
    end
  end

  // The matrix is symmetric, so a cell is folded onto its upper triangle.
  always_comb begin
    if (in_row_bin > in_col_bin) begin
      column = in_row_bin;
      diag   = in_row_bin - in_col_bin;
    end else begin
      column = in_col_bin;
      diag   = in_col_bin - in_row_bin;
    end
  end

  assign column_limit = {1'b0, bin_count_r} + (BINS_W + 1)'(band_width_r);
  assign in_band = (32'(diag) < 32'(band_width_r)) &&
                   ({1'b0, column} < column_limit) &&
                   (32'(diag) < MAX_DIAGONALS) &&
                   (32'(column) < ROW_STRIDE);

  assign cmd_in.mode    = mode_t'(in_mode);
  assign cmd_in.in_band = in_band;
  assign cmd_in.diag    = diag;
  assign cmd_in.column  = column;
  assign cmd_in.amount  = in_amount;

  assign in_full = cmd_full || hold;
  assign accept  = in_push && !in_full;

  bsc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_raw),
    .empty (cmd_empty)
  );

  assign cmd = cmd_t'(cmd_raw);

endmodule

/* rtl/bsc_back.sv */
`timescale 1ns / 1ps
// Back end: count store, clearing pass, read-modify-write sequencer and result queue.
// Depends on bsc_pkg and bsc_fifo.
module bsc_back
  import bsc_pkg::*;
#(
  parameter int MAX_DIAGONALS = MAX_DIAGONALS_DEF,
  parameter int MAX_BINS      = MAX_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output logic               clearing,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [VALUE_W-1:0] out_cell_value,
  output logic [1:0]         out_status
);

  localparam int ROW_STRIDE = MAX_BINS + MAX_DIAGONALS;
  localparam int DEPTH      = MAX_DIAGONALS * ROW_STRIDE;
  localparam int AW         = $clog2(DEPTH);
  localparam int DW         = (MAX_DIAGONALS > 1) ? $clog2(MAX_DIAGONALS) : 1;

  logic [VALUE_W-1:0] mem [DEPTH];

  seq_state_t         state_r, state_nxt;
  cmd_t               cmd_r;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [VALUE_W-1:0] rd_data_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [VALUE_W:0]   sum;
  result_t            res;
  result_t            res_out;
  logic               res_push, res_full;
  logic [$bits(result_t)-1:0] res_raw;

  assign clearing = (state_r == ST_CLEAR);
  assign addr_nxt = AW'(32'(cmd.diag[DW-1:0]) * 32'(ROW_STRIDE) + 32'(cmd.column));
  assign sum      = {1'b0, rd_data_r} + {1'b0, cmd_r.amount};

  always_comb begin
    res.cell_value = rd_data_r;
    res.status     = STAT_OK;
    if (!cmd_r.in_band) begin
      res.cell_value = '0;
      res.status     = STAT_OUTSIDE;
    end else begin
      case (cmd_r.mode)
        MODE_INC: begin
          if (sum[VALUE_W]) begin
            res.cell_value = '1;
            res.status     = STAT_SATURATED;
          end else begin
            res.cell_value = sum[VALUE_W-1:0];
          end
        end
        MODE_SET: begin
          res.cell_value = cmd_r.amount;
        end
        MODE_DEC: begin
          if (cmd_r.amount > rd_data_r) begin
            res.cell_value = '0;
            res.status     = STAT_CLAMPED;
          end else begin
            res.cell_value = rd_data_r - cmd_r.amount;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_r;
    mem_wdata   = res.cell_value;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // An in-band cell is written back in the same cycle the result is queued.
        if (!res_full) begin
          res_push  = 1'b1;
          mem_we    = cmd_r.in_band;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r  <= cmd;
      addr_r <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[addr_r];
  end

  bsc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_QUEUE_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_raw),
    .empty (out_empty)
  );

  assign res_out        = result_t'(res_raw);
  assign out_cell_value = res_out.cell_value;
  assign out_status     = res_out.status;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for banded_symmetric_count_matrix_top: directed and random cell
// accesses over several band and bin settings, checked against a cell-count predictor.
// Depends on bsc_pkg and the RTL of the block.
module tb;
  import bsc_pkg::*;

  localparam int STRIDE        = MAX_BINS_DEF + MAX_DIAGONALS_DEF;
  localparam int STALL_LIMIT   = 60000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOT_CELLS     = 6;
  localparam int PHASE_ITEMS   = 110;
  localparam int PHASES        = 8;

  // Raw register writes; several lie outside the legal range on purpose.
  localparam logic [CFG_DATA_W-1:0] BAND_SETTINGS [PHASES] = '{1, 16, 0, 31, 8, 3, 20, 16};
  localparam logic [CFG_DATA_W-1:0] BIN_SETTINGS  [PHASES] =
    '{1, 5, 0, 2047, 100, 1024, 37, 1024};

  typedef struct packed {
    mode_t               mode;
    logic [COORD_W-1:0]  row_bin;
    logic [COORD_W-1:0]  col_bin;
    logic [VALUE_W-1:0]  amount;
  } access_t;

  class cell_ledger;
    logic [VALUE_W-1:0] band_counts [MAX_DIAGONALS_DEF * STRIDE];
    int                 band_width;
    int                 bin_count;
    result_t            expected_cells [$];
    int                 fail_count;

    function new();
      foreach (band_counts[i]) band_counts[i] = '0;
      band_width = BAND_WIDTH_RESET;
      bin_count  = BIN_COUNT_RESET;
      fail_count = 0;
    endfunction

    task report(string msg);
      fail_count++;
      if (fail_count <= 100) $display("tb: mismatch: %s", msg);
    endtask

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] wdata);
      int v;
      if (idx == REG_BAND_WIDTH) begin
        v = int'(wdata[BAND_W-1:0]);
        band_width = (v < 1) ? 1 : (v > MAX_DIAGONALS_DEF) ? MAX_DIAGONALS_DEF : v;
      end else begin
        v = int'(wdata);
        bin_count = (v < 1) ? 1 : (v > MAX_BINS_DEF) ? MAX_BINS_DEF : v;
      end
    endfunction

    function void note_access(access_t a);
      int                 diag;
      int                 column;
      int                 addr;
      logic [VALUE_W-1:0] cur;
      logic [VALUE_W:0]   sum;
      result_t            r;
      if (a.row_bin > a.col_bin) begin
        column = int'(a.row_bin);
        diag   = int'(a.row_bin) - int'(a.col_bin);
      end else begin
        column = int'(a.col_bin);
        diag   = int'(a.col_bin) - int'(a.row_bin);
      end
      if (diag >= band_width || column >= bin_count + band_width) begin
        r.cell_value = '0;
        r.status     = STAT_OUTSIDE;
      end else begin
        addr     = diag * STRIDE + column;
        cur      = band_counts[addr];
        r.status = STAT_OK;
        case (a.mode)
          MODE_INC: begin
            sum = {1'b0, cur} + {1'b0, a.amount};
            if (sum[VALUE_W]) begin
              cur      = '1;
              r.status = STAT_SATURATED;
            end else begin
              cur = sum[VALUE_W-1:0];
            end
          end
          MODE_SET: cur = a.amount;
          MODE_DEC: begin
            if (a.amount > cur) begin
              cur      = '0;
              r.status = STAT_CLAMPED;
            end else begin
              cur = cur - a.amount;
            end
          end
          default: ;
        endcase
        band_counts[addr] = cur;
        r.cell_value      = cur;
      end
      expected_cells.push_back(r);
    endfunction

    task check_cell(logic [VALUE_W-1:0] value, logic [1:0] status);
      result_t want;
      if (expected_cells.size() == 0) begin
        report($sformatf("result with nothing pending: value %h status %0d", value, status));
        return;
      end
      want = expected_cells.pop_front();
      if (value !== want.cell_value)
        report($sformatf("cell_value %h, predicted %h", value, want.cell_value));
      if (status !== want.status)
        report($sformatf("status %0d, predicted %0d", status, want.status));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  logic [1:0]            in_mode;
  logic [COORD_W-1:0]    in_row_bin;
  logic [COORD_W-1:0]    in_col_bin;
  logic [VALUE_W-1:0]    in_amount;
  logic                  in_full;
  logic                  out_pop;
  logic                  out_empty;
  logic [VALUE_W-1:0]    out_cell_value;
  logic [1:0]            out_status;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cell_ledger ledger;
  int         results_seen = 0;
  int         idle_cycles  = 0;
  int         burst_left   = 0;
  int         hot_diag   [HOT_CELLS];
  int         hot_column [HOT_CELLS];

  banded_symmetric_count_matrix_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_mode       (in_mode),
    .in_row_bin    (in_row_bin),
    .in_col_bin    (in_col_bin),
    .in_amount     (in_amount),
    .in_full       (in_full),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_cell_value(out_cell_value),
    .out_status    (out_status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Every transfer is observed here, at the rising edge, before the block updates.
  always @(posedge clk) begin
    access_t seen;
    logic    moved;
    if (rst_n === 1'b1) begin
      moved = 1'b0;
      if (in_push && !in_full) begin
        seen.mode    = mode_t'(in_mode);
        seen.row_bin = in_row_bin;
        seen.col_bin = in_col_bin;
        seen.amount  = in_amount;
        ledger.note_access(seen);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        ledger.write_reg(cfg_reg_t'(cfg_index), cfg_wdata);
        moved = 1'b1;
      end
      if (out_pop && !out_empty) begin
        ledger.check_cell(out_cell_value, out_status);
        results_seen++;
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: a changing stall pattern, plus two long hold-offs that fill the block.
  initial begin
    int pattern;
    int pattern_left;
    int hold_left;
    int holds_done;
    out_pop      = 1'b0;
    pattern      = 0;
    pattern_left = 0;
    hold_left    = 0;
    holds_done   = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done < 2 && results_seen >= 150 + 450 * holds_done) begin
        hold_left = 300;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern      = $urandom_range(0, 3);
          pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        case (pattern)
          0: out_pop <= 1'b1;
          1: out_pop <= ($urandom_range(0, 3) != 0);
          2: out_pop <= ($urandom_range(0, 3) == 0);
          default: out_pop <= !out_pop;
        endcase
      end
    end
  end

  function automatic access_t cell_op(mode_t m, int r, int c, logic [VALUE_W-1:0] amt);
    access_t a;
    a.mode    = m;
    a.row_bin = r[COORD_W-1:0];
    a.col_bin = c[COORD_W-1:0];
    a.amount  = amt;
    return a;
  endfunction

  // Mostly cells in or just beyond the band; hot cells are hit often enough to
  // reach saturation and clamping, and a share of accesses is pure noise.
  function automatic access_t random_access();
    access_t a;
    int      pick;
    int      diag;
    int      column;
    int      k;
    a.mode = mode_t'($urandom_range(0, 3));
    pick   = $urandom_range(0, 99);
    if (pick < 10) begin
      a.row_bin = COORD_W'($urandom_range(0, 2047));
      a.col_bin = COORD_W'($urandom_range(0, 2047));
    end else begin
      if (pick < 40) begin
        k      = $urandom_range(0, HOT_CELLS - 1);
        diag   = hot_diag[k];
        column = hot_column[k];
      end else begin
        diag   = $urandom_range(0, ledger.band_width);
        column = $urandom_range(diag, ledger.bin_count + ledger.band_width);
      end
      if ($urandom_range(0, 1) == 1) begin
        a.row_bin = COORD_W'(column);
        a.col_bin = COORD_W'(column - diag);
      end else begin
        a.row_bin = COORD_W'(column - diag);
        a.col_bin = COORD_W'(column);
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 25)
      a.amount = $urandom_range(0, 15);
    else if (pick < 45)
      a.amount = 32'hFFFF_FFFF - $urandom_range(0, 15);
    else if (pick < 55)
      a.amount = ($urandom_range(0, 1) == 1) ? '1 : '0;
    else
      a.amount = $urandom;
    return a;
  endfunction

  // Sender: bursts of random length, separated by random gaps or none at all.
  task automatic send_access(input access_t a);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk) in_push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_push    <= 1'b1;
    in_mode    <= a.mode;
    in_row_bin <= a.row_bin;
    in_col_bin <= a.col_bin;
    in_amount  <= a.amount;
    do @(posedge clk); while (in_full);
    burst_left--;
  endtask

  task automatic pause_until_drained();
    @(negedge clk) in_push <= 1'b0;
    burst_left = 0;
    while (ledger.expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  initial begin
    access_t plan [$];
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_mode    = MODE_GET;
    in_row_bin = '0;
    in_col_bin = '0;
    in_amount  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_BAND_WIDTH;
    cfg_wdata  = '0;
    ledger     = new();
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed part under the reset settings: limits of the counter, symmetry,
    // the edges of the band and of the stored columns, and noise coordinates.
    plan.push_back(cell_op(MODE_GET, 0, 0, 32'h1234_5678));
    plan.push_back(cell_op(MODE_INC, 0, 0, 32'hFFFF_FFFF));
    plan.push_back(cell_op(MODE_INC, 0, 0, 32'h0000_0001));
    plan.push_back(cell_op(MODE_DEC, 0, 0, 32'h0000_0000));
    plan.push_back(cell_op(MODE_SET, 5, 3, 32'd100));
    plan.push_back(cell_op(MODE_GET, 3, 5, 32'd0));
    plan.push_back(cell_op(MODE_DEC, 3, 5, 32'd101));
    plan.push_back(cell_op(MODE_DEC, 3, 5, 32'd0));
    plan.push_back(cell_op(MODE_SET, 0, 15, 32'd7));
    plan.push_back(cell_op(MODE_INC, 15, 0, 32'd3));
    plan.push_back(cell_op(MODE_INC, 16, 0, 32'd1));
    plan.push_back(cell_op(MODE_SET, 1039, 1024, 32'hDEAD_BEEF));
    plan.push_back(cell_op(MODE_GET, 1024, 1039, 32'hFFFF_FFFF));
    plan.push_back(cell_op(MODE_SET, 1040, 1040, 32'd1));
    plan.push_back(cell_op(MODE_INC, 0, 2047, 32'd1));
    plan.push_back(cell_op(MODE_SET, 2047, 2047, 32'd5));
    plan.push_back(cell_op(MODE_SET, 1023, 1023, 32'hFFFF_FFFF));
    plan.push_back(cell_op(MODE_DEC, 1023, 1023, 32'hFFFF_FFFF));
    plan.push_back(cell_op(MODE_SET, 1, 1, 32'h5555_5555));
    plan.push_back(cell_op(MODE_INC, 1, 1, 32'hAAAA_AAAA));
    plan.push_back(cell_op(MODE_DEC, 1, 1, 32'hFFFF_FFFF));
    foreach (plan[i]) send_access(plan[i]);

    for (int p = 0; p < PHASES; p++) begin
      pause_until_drained();
      set_register(REG_BAND_WIDTH, BAND_SETTINGS[p]);
      set_register(REG_BIN_COUNT, BIN_SETTINGS[p]);
      for (int k = 0; k < HOT_CELLS; k++) begin
        hot_diag[k]   = $urandom_range(0, ledger.band_width - 1);
        hot_column[k] = $urandom_range(hot_diag[k], ledger.bin_count + ledger.band_width - 1);
      end
      repeat (PHASE_ITEMS) send_access(random_access());
    end

    pause_until_drained();
    if (ledger.expected_cells.size() != 0) ledger.report("results still pending at the end");
    if (ledger.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
